>>> hdl/lnp_pkg.sv
// Package with the shared types, codes and constants of the next-permutation block.
`timescale 1ns / 1ps

package lnp_pkg;

    // Sizes of the fields and of the sequence store.
    localparam int LNP_MAX_LEN  = 16;
    localparam int LNP_EMIT_CAP = 16;
    localparam int LNP_LEN_W    = 5;
    localparam int LNP_IDX_W    = 4;
    localparam int LNP_VAL_W    = 8;
    localparam int LNP_ADDR_W   = 3;
    localparam int LNP_DATA_W   = 32;

    localparam logic [LNP_LEN_W-1:0] LNP_LEN_RESET = 5'd8;

    // Register index of the length register (taken from paddr bit 2).
    localparam logic REG_LENGTH = 1'b0;

    // Function codes of an input word.
    typedef enum logic
    {
        FUNC_WRITE   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } lnp_func_t;

    // Payload of one input word.
    typedef struct packed
    {
        logic                 func;
        logic [LNP_IDX_W-1:0] position;
        logic [LNP_VAL_W-1:0] value;
    } lnp_item_t;

    // Payload of one result word.
    typedef struct packed
    {
        logic [LNP_VAL_W-1:0] element;
        logic [LNP_IDX_W-1:0] element_index;
        logic                 last;
        logic                 done_res;
    } lnp_result_t;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0]
    {
        OP_NONE,
        OP_WRITE,
        OP_START,
        OP_PIV_FIRST,
        OP_PIV_STEP,
        OP_K_STEP,
        OP_SWAP,
        OP_REV_TEST,
        OP_REV_A,
        OP_REV_B,
        OP_REV_WB,
        OP_EMIT,
        OP_DONE
    } lnp_op_t;

    // Controller states.
    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_PIV_FIRST,
        ST_PIV_STEP,
        ST_K_STEP,
        ST_SWAP,
        ST_REV_TEST,
        ST_REV_A,
        ST_REV_B,
        ST_REV_WB,
        ST_EMIT,
        ST_DONE
    } lnp_state_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic piv_zero;
        logic piv_one;
        logic prev_ge;
        logic k_hit;
        logic lo_lt_hi;
        logic emit_last;
        logic out_free;
    } lnp_status_t;

endpackage

>>> hdl/lnp_stream_if.sv
// Valid/ready stream interface carrying one payload word per handshake.
`timescale 1ns / 1ps

interface lnp_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> hdl/lnp_datapath.sv
// Datapath: sequence store, scan counters, working registers and the result register.
`timescale 1ns / 1ps

module lnp_datapath
    import lnp_pkg::*;
#(
    parameter int MAX_LEN = LNP_MAX_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lnp_op_t              op,
    input  logic [LNP_LEN_W-1:0] length,
    input  lnp_item_t            item_data,
    input  logic                 result_ready,
    output logic                 result_valid,
    output lnp_result_t          result_data,
    output lnp_status_t          status
);

    localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LIM = (MAX_LEN < LNP_EMIT_CAP) ? MAX_LEN : LNP_EMIT_CAP;

    // Sequence store with a valid bit for each entry.
    logic [LNP_VAL_W-1:0] mem [MAX_LEN];
    logic [MAX_LEN-1:0]   valid_reg;

    logic [LNP_IDX_W-1:0] last_reg, last_next;
    logic [LNP_IDX_W-1:0] piv_reg, piv_next;
    logic [LNP_IDX_W-1:0] k_reg, k_next;
    logic [LNP_IDX_W-1:0] lo_reg, lo_next;
    logic [LNP_IDX_W-1:0] hi_reg, hi_next;
    logic [LNP_IDX_W-1:0] i_reg, i_next;
    logic [LNP_VAL_W-1:0] cur_reg, cur_next;
    logic [LNP_VAL_W-1:0] pv_reg, pv_next;
    logic [LNP_VAL_W-1:0] kv_reg, kv_next;
    logic [LNP_VAL_W-1:0] a_reg, a_next;
    logic [LNP_VAL_W-1:0] rd_data_reg;
    lnp_result_t          out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [LNP_LEN_W-1:0] act_len;
    logic [LNP_IDX_W-1:0] act_last;
    logic                 rd_en;
    logic [LNP_IDX_W-1:0] rd_idx;
    logic                 wr_en;
    logic [LNP_IDX_W-1:0] wr_idx;
    logic [LNP_VAL_W-1:0] wr_data;
    logic                 out_load;
    logic [AW-1:0]        ra;
    logic [AW-1:0]        wa;

    // Clamp the configured length to the range that takes part.
    always_comb
    begin
        if (length == '0)
        begin
            act_len = LNP_LEN_W'(1);
        end
        else if (32'(length) > LIM)
        begin
            act_len = LNP_LEN_W'(LIM);
        end
        else
        begin
            act_len = length;
        end
        act_last = LNP_IDX_W'(act_len - LNP_LEN_W'(1));
    end

    // Status towards the controller.
    always_comb
    begin
        status.piv_zero  = (piv_reg == '0);
        status.piv_one   = (piv_reg == LNP_IDX_W'(1));
        status.prev_ge   = (rd_data_reg >= cur_reg);
        status.k_hit     = (rd_data_reg > pv_reg);
        status.lo_lt_hi  = (lo_reg < hi_reg);
        status.emit_last = (i_reg == last_reg);
        status.out_free  = !out_valid_reg || result_ready;
    end

    // Command decode: memory accesses and register updates.
    always_comb
    begin
        last_next = last_reg;
        piv_next  = piv_reg;
        k_next    = k_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        i_next    = i_reg;
        cur_next  = cur_reg;
        pv_next   = pv_reg;
        kv_next   = kv_reg;
        a_next    = a_reg;
        rd_en     = 1'b0;
        rd_idx    = '0;
        wr_en     = 1'b0;
        wr_idx    = '0;
        wr_data   = '0;
        out_load  = 1'b0;
        out_next  = out_reg;

        case (op)
            OP_WRITE:
            begin
                wr_en   = (32'(item_data.position) < MAX_LEN);
                wr_idx  = item_data.position;
                wr_data = item_data.value;
            end
            OP_START:
            begin
                last_next = act_last;
                piv_next  = act_last;
                rd_en     = 1'b1;
                rd_idx    = act_last;
            end
            OP_PIV_FIRST:
            begin
                cur_next = rd_data_reg;
                if (!status.piv_zero)
                begin
                    rd_en  = 1'b1;
                    rd_idx = piv_reg - LNP_IDX_W'(1);
                end
            end
            OP_PIV_STEP:
            begin
                if (status.prev_ge)
                begin
                    cur_next = rd_data_reg;
                    piv_next = piv_reg - LNP_IDX_W'(1);
                    if (!status.piv_one)
                    begin
                        rd_en  = 1'b1;
                        rd_idx = piv_reg - LNP_IDX_W'(2);
                    end
                end
                else
                begin
                    // Pivot found: start the search for its successor at the end.
                    pv_next = rd_data_reg;
                    k_next  = last_reg;
                    rd_en   = 1'b1;
                    rd_idx  = last_reg;
                end
            end
            OP_K_STEP:
            begin
                if (status.k_hit)
                begin
                    kv_next = rd_data_reg;
                    wr_en   = 1'b1;
                    wr_idx  = k_reg;
                    wr_data = pv_reg;
                end
                else
                begin
                    k_next = k_reg - LNP_IDX_W'(1);
                    rd_en  = 1'b1;
                    rd_idx = k_reg - LNP_IDX_W'(1);
                end
            end
            OP_SWAP:
            begin
                wr_en   = 1'b1;
                wr_idx  = piv_reg - LNP_IDX_W'(1);
                wr_data = kv_reg;
                lo_next = piv_reg;
                hi_next = last_reg;
            end
            OP_REV_TEST:
            begin
                rd_en = 1'b1;
                if (status.lo_lt_hi)
                begin
                    rd_idx = lo_reg;
                end
                else
                begin
                    i_next = '0;
                    rd_idx = '0;
                end
            end
            OP_REV_A:
            begin
                a_next = rd_data_reg;
                rd_en  = 1'b1;
                rd_idx = hi_reg;
            end
            OP_REV_B:
            begin
                wr_en   = 1'b1;
                wr_idx  = lo_reg;
                wr_data = rd_data_reg;
            end
            OP_REV_WB:
            begin
                wr_en   = 1'b1;
                wr_idx  = hi_reg;
                wr_data = a_reg;
                lo_next = lo_reg + LNP_IDX_W'(1);
                hi_next = hi_reg - LNP_IDX_W'(1);
            end
            OP_EMIT:
            begin
                if (status.out_free)
                begin
                    out_load               = 1'b1;
                    out_next.element       = rd_data_reg;
                    out_next.element_index = i_reg;
                    out_next.last          = status.emit_last;
                    out_next.done_res      = 1'b0;
                    if (!status.emit_last)
                    begin
                        i_next = i_reg + LNP_IDX_W'(1);
                        rd_en  = 1'b1;
                        rd_idx = i_reg + LNP_IDX_W'(1);
                    end
                end
            end
            OP_DONE:
            begin
                if (status.out_free)
                begin
                    out_load               = 1'b1;
                    out_next.element       = '0;
                    out_next.element_index = '0;
                    out_next.last          = 1'b1;
                    out_next.done_res      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign ra = AW'(rd_idx);
    assign wa = AW'(wr_idx);

    // Control flags: result valid and the per-entry valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                valid_reg[wa] <= 1'b1;
            end
        end
    end

    // Memory write and registered read; an unwritten entry reads as its index plus one.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wa] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[ra] ? mem[ra] : LNP_VAL_W'(32'(ra) + 1);
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        piv_reg  <= piv_next;
        k_reg    <= k_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        i_reg    <= i_next;
        cur_reg  <= cur_next;
        pv_reg   <= pv_next;
        kv_reg   <= kv_next;
        a_reg    <= a_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

>>> hdl/lnp_ctrl.sv
// Controller: state machine that sequences the datapath through one advance.
`timescale 1ns / 1ps

module lnp_ctrl
    import lnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_func,
    input  lnp_status_t status,
    output logic        item_ready,
    output lnp_op_t     op
);

    lnp_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        item_ready = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_func == FUNC_ADVANCE)
                    begin
                        op         = OP_START;
                        state_next = ST_PIV_FIRST;
                    end
                    else
                    begin
                        op = OP_WRITE;
                    end
                end
            end
            ST_PIV_FIRST:
            begin
                op         = OP_PIV_FIRST;
                state_next = status.piv_zero ? ST_DONE : ST_PIV_STEP;
            end
            ST_PIV_STEP:
            begin
                op = OP_PIV_STEP;
                if (!status.prev_ge)
                begin
                    state_next = ST_K_STEP;
                end
                else if (status.piv_one)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_K_STEP:
            begin
                op = OP_K_STEP;
                if (status.k_hit)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                op         = OP_SWAP;
                state_next = ST_REV_TEST;
            end
            ST_REV_TEST:
            begin
                op         = OP_REV_TEST;
                state_next = status.lo_lt_hi ? ST_REV_A : ST_EMIT;
            end
            ST_REV_A:
            begin
                op         = OP_REV_A;
                state_next = ST_REV_B;
            end
            ST_REV_B:
            begin
                op         = OP_REV_B;
                state_next = ST_REV_WB;
            end
            ST_REV_WB:
            begin
                op         = OP_REV_WB;
                state_next = ST_REV_TEST;
            end
            ST_EMIT:
            begin
                op = OP_EMIT;
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                op = OP_DONE;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lex_next_permutation.sv
// Top level of the lexicographic next-permutation engine with its register port.
//
// The block holds a sequence of MAX_LEN bytes, reset to 1, 2, 3 and so on. A write word
// stores one element. An advance word steps the first `length` elements (n, clamped to
// 1..min(MAX_LEN,16)) to the next permutation in lexicographic order and returns the new
// elements one word each, the final one marked last; when no greater permutation exists
// it returns one word with done_res set and leaves the sequence alone. All work goes
// through a single-port sequence memory with a registered read, one access per cycle: an
// advance scans back for the pivot, searches the tail from the end for its successor,
// swaps the two, reverses the tail and then emits the results as they are taken. The
// last result waits in an output register, so the next word is taken while it is still
// pending.
`timescale 1ns / 1ps

module lex_next_permutation
    import lnp_pkg::*;
#(
    parameter int MAX_LEN = LNP_MAX_LEN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lnp_stream_if.sink            item,
    lnp_stream_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LNP_ADDR_W-1:0] paddr,
    input  logic [LNP_DATA_W-1:0] pwdata,
    output logic [LNP_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LNP_LEN_W-1:0] length_reg;
    logic                 cfg_wr;
    lnp_op_t              op;
    lnp_status_t          status;
    lnp_item_t            item_data;
    lnp_result_t          result_data;

    // Register port: length register at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LNP_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            length_reg <= pwdata[LNP_LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_LENGTH)
        begin
            prdata = LNP_DATA_W'(length_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign item_data      = item.payload;
    assign result.payload = result_data;

    // Controller.
    lnp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item_data.func),
        .status     (status),
        .item_ready (item.ready),
        .op         (op)
    );

    // Datapath.
    lnp_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .length       (length_reg),
        .item_data    (item_data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_data  (result_data),
        .status       (status)
    );

    // A done answer is always the single, final word of its advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result_data.done_res) |-> result_data.last)
    else $error("done result without last mark");

    // A new word is only taken once every pending result but the final one is gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.ready && result.valid) |-> result_data.last)
    else $error("input taken while an advance is still emitting");

    // Within one advance the element index counts up by one from result to result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result_data.last) |=>
        (result.valid && (result_data.element_index ==
            LNP_IDX_W'($past(result_data.element_index) + 1'b1))))
    else $error("element index out of step");

endmodule

>>> test/tb_lex_next_permutation.sv
// Self-checking testbench for the lexicographic next-permutation block.
`timescale 1ns / 1ps

module tb_lex_next_permutation;

    import lnp_pkg::*;

    // Run control.
    localparam int  GAP_MAX        = 10;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  SETTLE_CYCLES  = 100;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  MAX_REPORTS    = 30;
    localparam int  RANDOM_PHASES  = 8;
    localparam int  PHASE_WORDS    = 18;
    localparam int  SEED_MAX       = 6;

    // Register index past the end of the register list; writes there are dropped.
    localparam logic REG_SPARE = 1'b1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [LNP_ADDR_W-1:0] paddr;
    logic [LNP_DATA_W-1:0] pwdata;
    logic [LNP_DATA_W-1:0] prdata;
    logic                  pready;

    lnp_stream_if #(.payload_t(lnp_item_t))   item_if ();
    lnp_stream_if #(.payload_t(lnp_result_t)) result_if ();

    // Shadow copy of the sequence store and the length register.
    logic [LNP_VAL_W-1:0] seq_shadow [LNP_MAX_LEN];
    logic [LNP_LEN_W-1:0] length_shadow;

    // Result words predicted but not yet seen, oldest first.
    lnp_result_t pending_results [$];

    int error_count;
    int quiet_cycles;
    bit gaps_on;
    bit hold_request;

    lex_next_permutation u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Counts a mismatch and prints a line for the first few.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb_lex_next_permutation: mismatch at %0t: %s", $realtime, what);
    endtask

    // Applies one accepted input word to the shadow state and queues the results it causes.
    task automatic step_permutation(input lnp_item_t w);
        int                   n;
        int                   piv;
        int                   k;
        int                   lo;
        int                   hi;
        logic [LNP_VAL_W-1:0] t;
        lnp_result_t          r;
        if (w.func == FUNC_WRITE)
        begin
            seq_shadow[w.position] = w.value;
        end
        else
        begin
            // Effective length: zero acts as one, large values saturate.
            n = int'(length_shadow);
            if (n < 1)
                n = 1;
            if (n > LNP_MAX_LEN)
                n = LNP_MAX_LEN;
            if (n > LNP_EMIT_CAP)
                n = LNP_EMIT_CAP;

            // The pivot sits just before the longest non-increasing tail.
            piv = n - 1;
            while (piv > 0 && seq_shadow[piv - 1] >= seq_shadow[piv])
                piv--;

            if (piv == 0)
            begin
                // Already the greatest arrangement: a single done word.
                r          = '0;
                r.last     = 1'b1;
                r.done_res = 1'b1;
                pending_results.push_back(r);
            end
            else
            begin
                // Swap the pivot with the rightmost larger tail element.
                k = n - 1;
                while (k > piv && seq_shadow[piv - 1] >= seq_shadow[k])
                    k--;
                t                   = seq_shadow[k];
                seq_shadow[k]       = seq_shadow[piv - 1];
                seq_shadow[piv - 1] = t;

                // Reverse the tail so that it becomes the smallest ordering.
                lo = piv;
                hi = n - 1;
                while (lo < hi)
                begin
                    t              = seq_shadow[lo];
                    seq_shadow[lo] = seq_shadow[hi];
                    seq_shadow[hi] = t;
                    lo++;
                    hi--;
                end

                for (int i = 0; i < n; i++)
                begin
                    r.element       = seq_shadow[i];
                    r.element_index = LNP_IDX_W'(i);
                    r.last          = (i == n - 1);
                    r.done_res      = 1'b0;
                    pending_results.push_back(r);
                end
            end
        end
    endtask

    // Checks each result word against the oldest prediction, then predicts from the input.
    always @(posedge clk)
    begin
        lnp_result_t got;
        lnp_result_t want;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got = result_if.payload;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word %h with nothing expected", got));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.element !== want.element)
                        report_mismatch($sformatf("element %h, expected %h",
                                                  got.element, want.element));
                    if (got.element_index !== want.element_index)
                        report_mismatch($sformatf("element_index %h, expected %h",
                                                  got.element_index, want.element_index));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  got.last, want.last));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res %b, expected %b",
                                                  got.done_res, want.done_res));
                end
            end
            if (item_if.valid && item_if.ready)
                step_permutation(item_if.payload);
        end
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready) || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_lex_next_permutation: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall before each word, or one long hold-off on request.
    initial
    begin : result_sink
        int stall;
        result_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    // Offers one input word after a random gap and returns at the edge that takes it.
    task automatic send_word(input lnp_item_t w);
        int gap;
        gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= w;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic write_element(input int pos, input int val);
        lnp_item_t w;
        w.func     = FUNC_WRITE;
        w.position = LNP_IDX_W'(pos);
        w.value    = LNP_VAL_W'(val);
        send_word(w);
    endtask

    // The position and value of an advance word are don't-care, so they are left random.
    task automatic advance_sequence();
        lnp_item_t w;
        w.func     = FUNC_ADVANCE;
        w.position = LNP_IDX_W'($urandom);
        w.value    = LNP_VAL_W'($urandom);
        send_word(w);
    endtask

    // Two-phase register write; the shadow follows only for the length register.
    task automatic write_register(input logic reg_index, input logic [LNP_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == REG_LENGTH)
            length_shadow = data[LNP_LEN_W-1:0];
    endtask

    // Stops offering words, waits for every expected result, then lets the block settle.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // From reset: 1..8 steps to 1..6,8,7 and then to 1..5,7,6,8.
    task automatic test_reset_sequence();
        advance_sequence();
        advance_sequence();
    endtask

    // Extreme positions and values, alternating bit patterns, then an advance.
    task automatic test_field_extremes();
        write_element(0, 0);
        write_element(15, 255);
        write_element(7, 8'hAA);
        write_element(6, 8'h55);
        advance_sequence();
    endtask

    // Repeated values: 1,2,2 runs through 2,1,2 and 2,2,1 and then reports done.
    task automatic test_duplicate_values();
        wait_idle();
        write_register(REG_LENGTH, 3);
        write_element(0, 1);
        write_element(1, 2);
        write_element(2, 2);
        advance_sequence();
        advance_sequence();
        advance_sequence();
    endtask

    // A length of one or zero always reports done; a write to the spare index changes nothing.
    task automatic test_short_lengths();
        wait_idle();
        write_register(REG_LENGTH, 1);
        advance_sequence();
        wait_idle();
        write_register(REG_LENGTH, 0);
        advance_sequence();
        wait_idle();
        write_register(REG_SPARE, 16);
        advance_sequence();
    endtask

    // Saturated and full lengths, then the shortest length that can still move.
    task automatic test_long_lengths();
        wait_idle();
        write_register(REG_LENGTH, 31);
        advance_sequence();
        wait_idle();
        write_register(REG_LENGTH, 16);
        advance_sequence();
        wait_idle();
        write_register(REG_LENGTH, 2);
        advance_sequence();
        advance_sequence();
    endtask

    // The result side holds off while full-length advances keep coming, so the block fills.
    task automatic test_output_backpressure();
        wait_idle();
        write_register(REG_LENGTH, 16);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (10) advance_sequence();
        gaps_on = 1'b1;
    endtask

    // Phases of seeded sequences walked forward by advances, with stray writes mixed in.
    task automatic test_random_walk();
        int len_pick;
        int n_eff;
        int seed_count;
        int seed_style;
        int base;
        int sent;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       len_pick = 0;
                1:       len_pick = 31;
                2:       len_pick = 16;
                3:       len_pick = $urandom_range(0, 31);
                default: len_pick = $urandom_range(2, 5);
            endcase
            write_register(REG_LENGTH, len_pick);
            gaps_on = ($urandom_range(0, 3) != 0);

            n_eff = (len_pick < 1) ? 1 : (len_pick > LNP_MAX_LEN) ? LNP_MAX_LEN : len_pick;
            seed_count = (n_eff > SEED_MAX) ? SEED_MAX : n_eff;
            seed_style = $urandom_range(0, 2);
            base       = $urandom_range(SEED_MAX, 255);

            // Seed: few distinct values, full range, or a falling run.
            sent = 0;
            for (int i = 0; i < seed_count; i++)
            begin
                case (seed_style)
                    0:       write_element(i, $urandom_range(0, 3));
                    1:       write_element(i, $urandom_range(0, 255));
                    default: write_element(i, base - i);
                endcase
                sent++;
            end

            // Mostly advances; now and then a write anywhere in the store.
            while (sent < PHASE_WORDS)
            begin
                if ($urandom_range(0, 4) == 0)
                    write_element($urandom_range(0, 15), $urandom_range(0, 255));
                else
                    advance_sequence();
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // Reset, then each test in turn, then the verdict.
    initial
    begin
        error_count   = 0;
        quiet_cycles  = 0;
        gaps_on       = 1'b1;
        hold_request  = 1'b0;
        length_shadow = LNP_LEN_RESET;
        for (int i = 0; i < LNP_MAX_LEN; i++)
            seq_shadow[i] = LNP_VAL_W'(i + 1);

        rst_n           <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.payload <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sequence();
        test_field_extremes();
        test_duplicate_values();
        test_short_lengths();
        test_long_lengths();
        test_output_backpressure();
        test_random_walk();

        wait_idle();
        if (error_count == 0)
            $display("tb_lex_next_permutation: done, clean");
        else
            $display("tb_lex_next_permutation: done, errors");
        $finish;
    end

endmodule

>>> files.f
hdl/lnp_pkg.sv
hdl/lnp_stream_if.sv
hdl/lnp_datapath.sv
hdl/lnp_ctrl.sv
hdl/lex_next_permutation.sv
test/tb_lex_next_permutation.sv
